// File: rtl/dfmt_pkg.sv
// shared types and constants for the decimal field formatter
`default_nettype none

package dfmt_pkg;

  localparam int VALUE_W  = 64;
  localparam int NUM_BCD  = 20;               // decimal digits of a 64-bit value
  localparam int BCD_W    = 4 * NUM_BCD;
  localparam int CNT_W    = 7;                // holds any field width up to 64
  localparam int NAT_W    = 5;                // holds 0..NUM_BCD
  localparam int SHIFT_CW = $clog2(VALUE_W);

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] PREC_DEFAULT = 8'hFF; // precision code meaning one digit

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   field_width;
    logic signed [7:0]  min_digits;
    logic               zero_fill;
    logic               right_align;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/dfmt_dabble.sv
// shift-and-add-3 binary to bcd converter, one bit per cycle
`default_nettype none

module dfmt_dabble
  import dfmt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    done,
  output logic [BCD_W-1:0]        bcd
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } dab_state_t;

  dab_state_t            state_r;
  logic [SHIFT_CW-1:0]   bit_cnt_r;
  logic [VALUE_W-1:0]    sh_r;
  logic [BCD_W-1:0]      bcd_r;
  logic                  done_r;
  logic [BCD_W-1:0]      adj;

  // every digit of five or more gets three added before the shift
  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      done_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r   <= ST_RUN;
            bit_cnt_r <= '0;
            sh_r      <= value;
            bcd_r     <= '0;
          end
        end
        ST_RUN: begin
          bcd_r     <= {adj[BCD_W-2:0], sh_r[VALUE_W-1]};
          sh_r      <= {sh_r[VALUE_W-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_cnt_r == SHIFT_CW'(VALUE_W - 1)) begin
            state_r <= ST_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

// File: rtl/decimal_field_formatter.sv
// top level: decimal field formatter, one ascii character per output word
//
//  channel | direction | payload    | handshake
//  in_     | input     | in_word_t  | in_valid / in_ready
//  out_    | output    | out_word_t | out_valid / out_ready
//
// an item is accepted, converted in the bit-serial bcd converter (one value bit
// per cycle), its field sized, then its characters sent, max(digit count, field
// width) of them, one per cycle while out_ready stays high. out_ready low
// stretches only the character phase. in_ready is high only between items.
// rst_n is synchronous and clears control state; there is no clearing pass.
`default_nettype none

module decimal_field_formatter
  import dfmt_pkg::*;
#(
  parameter int MAX_FIELD = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] width_r, width_nxt;
  logic [CNT_W-1:0] prec_r, prec_nxt;
  logic             zfill_r, zfill_nxt;
  logic             ralign_r, ralign_nxt;
  logic [CNT_W-1:0] padc_r, padc_nxt;
  logic [CNT_W-1:0] digc_r, digc_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic             conv_start;
  logic             conv_done;
  logic [BCD_W-1:0] bcd;

  logic [NAT_W-1:0] nat;
  logic [CNT_W-1:0] ndig;
  logic [CNT_W-1:0] idx;
  logic [3:0]       nib;
  logic             emit_pad;
  logic             load;

  dfmt_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (in_data.value),
    .done  (conv_done),
    .bcd   (bcd)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign conv_start = in_valid && in_ready;

  // highest nonzero bcd digit gives the natural digit count, zero has none
  always_comb begin
    nat = '0;
    for (int i = 0; i < NUM_BCD; i++) begin
      if (bcd[4*i +: 4] != 4'd0) nat = NAT_W'(i + 1);
    end
  end

  assign ndig = ({2'b00, nat} > prec_r) ? {2'b00, nat} : prec_r;

  // digits are counted down from the most significant, beyond the bcd word
  // they are leading zeros
  assign idx = digc_r - 1'b1;
  assign nib = (idx < CNT_W'(NUM_BCD)) ? bcd[4*idx[NAT_W-1:0] +: 4] : 4'd0;

  assign emit_pad = (ralign_r && padc_r != '0) || (digc_r == '0);
  assign load     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    zfill_nxt     = zfill_r;
    ralign_nxt    = ralign_r;
    padc_nxt      = padc_r;
    digc_nxt      = digc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (conv_start) begin
          state_nxt  = S_CONV;
          zfill_nxt  = in_data.zero_fill;
          ralign_nxt = in_data.right_align;
          width_nxt  = (in_data.field_width > CNT_W'(MAX_FIELD)) ?
                       CNT_W'(MAX_FIELD) : in_data.field_width;
          if (in_data.min_digits == PREC_DEFAULT) begin
            prec_nxt = CNT_W'(1);
          end else if (in_data.min_digits[7]) begin
            prec_nxt = '0;
          end else if (in_data.min_digits[CNT_W-1:0] > CNT_W'(MAX_FIELD)) begin
            prec_nxt = CNT_W'(MAX_FIELD);
          end else begin
            prec_nxt = in_data.min_digits[CNT_W-1:0];
          end
        end
      end
      S_CONV: begin
        if (conv_done) state_nxt = S_SIZE;
      end
      S_SIZE: begin
        digc_nxt = ndig;
        padc_nxt = (width_r > ndig) ? width_r - ndig : '0;
        if (ndig == '0 && width_r == '0) state_nxt = S_IDLE;
        else                             state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.last_char = ((padc_r + digc_r) == CNT_W'(1));
          if (emit_pad) begin
            out_data_nxt.character = zfill_r ? CHAR_ZERO : CHAR_SPACE;
            padc_nxt = padc_r - 1'b1;
          end else begin
            out_data_nxt.character = CHAR_ZERO | {4'b0000, nib};
            digc_nxt = digc_r - 1'b1;
          end
          if ((padc_r + digc_r) == CNT_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    zfill_r    <= zfill_nxt;
    ralign_r   <= ralign_nxt;
    padc_r     <= padc_nxt;
    digc_r     <= digc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/dfmt_checker.sv
// port-level checks for the decimal field formatter and their bind
`default_nettype none

module dfmt_checker
  import dfmt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // one value at a time: the converter is busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a word");

  // a pending word that is not the field's last means the item is still open
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_char |-> !in_ready)
    else $error("new value taken mid field");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.character == CHAR_SPACE) ||
                  ((out_data.character >= CHAR_ZERO) && (out_data.character <= 8'h39)))
    else $error("character is neither digit nor space");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind decimal_field_formatter dfmt_checker u_dfmt_checker (.*);

`default_nettype wire
